FILE: src/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key/value cache: entry layout,
// per-cell control bundle and item kind codes.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Item kind carried in the input tuser bit
    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_WRITE  = 1'b1
    } kind_t;

    // One cache entry as it moves along the recency chain
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Control handed from the sequencer to each cell
    typedef struct packed {
        logic capture;  // latch the key compare for a new transfer
        logic shift;    // load the entry of the more recent neighbor
    } cell_ctl_t;

endpackage

FILE: src/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement,
// kept as a chain of cells ordered by recency (cell 0 most recent).
// Timing: the item and the cell key compares are registered on the input
//   transfer, then the chain update registers the result; a held result on
//   the output delays the chain update until it is taken. A new item is
//   accepted only after the previous one has updated the chain.
// Reset: clears all valid bits and the fill count and sets capacity to 16;
//   no clearing pass, the block accepts as soon as reset is released.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration: capacity
    input  logic                         cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]    cfg_wr_data,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,   // [31:0] key, [63:32] value
    input  logic                         s_tuser,   // [0] kind
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [31:0] read_value
    output logic [1:0]                   m_tuser    // [0] found, [1] evicted
);

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CW     = (FILL_W > lkv_pkg::CAP_W) ? FILL_W : lkv_pkg::CAP_W;

    // Configuration and control state
    logic [lkv_pkg::CAP_W-1:0]   cap_reg;
    logic                        busy_reg,  busy_next;
    logic [FILL_W-1:0]           fill_reg,  fill_next;
    lkv_pkg::kind_t              kind_reg;
    logic [lkv_pkg::KEY_W-1:0]   key_reg;
    logic [lkv_pkg::VALUE_W-1:0] value_reg;

    // Output register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [31:0]                 m_tdata_reg;
    logic [1:0]                  m_tuser_reg;

    // Chain signals
    lkv_pkg::entry_t             head;
    lkv_pkg::entry_t             link  [ENTRIES];
    lkv_pkg::cell_ctl_t          ctl   [ENTRIES];
    logic [ENTRIES-1:0]          match_vec;
    logic [ENTRIES-1:0]          valid_vec;
    logic [ENTRIES-1:0]          hit_sfx;

    logic                        in_xfer;
    logic                        go;
    logic                        hit;
    logic                        full;
    logic [FILL_W-1:0]           limit;
    logic [lkv_pkg::VALUE_W-1:0] hit_value;
    logic [CW-1:0]               cap_ext;
    logic [CW-1:0]               eff_cap;

    assign s_tready = aresetn && !busy_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign go       = busy_reg && (!m_tvalid_reg || m_tready);

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lkv_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Clamp capacity to 1..ENTRIES
    always_comb begin
        cap_ext = CW'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(ENTRIES)) begin
            eff_cap = CW'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    // Latch the accepted item
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg  <= lkv_pkg::kind_t'(s_tuser);
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
        end
    end

    // Hit detection and read-out over the chain
    assign hit  = |match_vec;
    assign full = CW'(fill_reg) >= eff_cap;

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_value = hit_value | (match_vec[i] ? link[i].value : '0);
        end
    end

    // Cells up to and including the hit position shift toward the tail
    for (genvar g = 0; g < ENTRIES; g++) begin : g_sfx
        assign hit_sfx[g] = |match_vec[ENTRIES-1:g];
    end

    // Deepest cell that shifts on a miss write: drop the tail entry when full
    assign limit = full ? (fill_reg - FILL_W'(1)) : fill_reg;

    // New most recent entry enters at the head
    always_comb begin
        head.valid = 1'b1;
        head.key   = key_reg;
        head.value = (kind_reg == lkv_pkg::KIND_WRITE) ? value_reg : hit_value;
    end

    // Recency chain
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_pkg::entry_t prev_entry;

        if (g == 0) begin : g_head
            assign prev_entry = head;
        end else begin : g_link
            assign prev_entry = link[g-1];
        end

        assign ctl[g].capture = in_xfer;
        assign ctl[g].shift   = go && (hit ? hit_sfx[g]
                                : ((kind_reg == lkv_pkg::KIND_WRITE)
                                   && (FILL_W'(g) <= limit)));

        lkv_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl[g]),
            .cmp_key (s_tdata[31:0]),
            .prev    (prev_entry),
            .cur     (link[g]),
            .match   (match_vec[g])
        );

        assign valid_vec[g] = link[g].valid;
    end

    // Control next state
    always_comb begin
        busy_next     = busy_reg;
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (in_xfer) begin
            busy_next = 1'b1;
        end
        if (go) begin
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
            if ((kind_reg == lkv_pkg::KIND_WRITE) && !hit && !full) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (go) begin
            m_tdata_reg    <= (hit && (kind_reg == lkv_pkg::KIND_LOOKUP)) ? hit_value : '0;
            m_tuser_reg[0] <= hit;
            m_tuser_reg[1] <= (kind_reg == lkv_pkg::KIND_WRITE) && !hit && full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Keys are unique among valid entries
    a_match_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // Valid cells track the fill count
    a_fill_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(fill_reg))
        else $error("valid cells disagree with fill count");

    // Fill never exceeds the chain length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= ENTRIES)
        else $error("fill count beyond chain length");

    // A chain update always presents a result next
    a_result_after_go: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> (m_tvalid_reg && !busy_reg))
        else $error("update did not produce a result");

    // An eviction never comes with a hit
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tuser_reg[0] && m_tuser_reg[1]))
        else $error("eviction reported on a hit");

endmodule

FILE: src/lkv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_cell
// One position of the recency chain. Holds an entry, compares its key with
// the incoming key, and takes its more recent neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module lkv_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lkv_pkg::cell_ctl_t                 ctl,
    input  logic [lkv_pkg::KEY_W-1:0]          cmp_key,
    input  lkv_pkg::entry_t                    prev,
    output lkv_pkg::entry_t                    cur,
    output logic                               match
);

    logic                          valid_reg;
    logic [lkv_pkg::KEY_W-1:0]     key_reg;
    logic [lkv_pkg::VALUE_W-1:0]   value_reg;
    logic                          match_reg;

    // Valid bit follows the neighbor on a shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.shift) begin
            valid_reg <= prev.valid;
        end
    end

    // Payload follows the neighbor on a shift
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            key_reg   <= prev.key;
            value_reg <= prev.value;
        end
    end

    // Hold the key compare of the accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctl.capture) begin
            match_reg <= valid_reg && (key_reg == cmp_key);
        end
    end

    assign cur.valid = valid_reg;
    assign cur.key   = key_reg;
    assign cur.value = value_reg;
    assign match     = match_reg;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the LRU key/value cache. Lookups and writes are streamed in
// bursts while the result side stalls on its own pattern. A local model of
// the recency-ranked store predicts found, read_value and evicted for every
// transfer, and each result is checked against the oldest prediction. The
// capacity register is swept through in-range, zero and oversized settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CAP_W       = lkv_pkg::CAP_W;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        evicted;
    } access_result_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata     = '0;    // [31:0] key, [63:32] value
    logic              s_tuser     = 1'b0;  // [0] kind
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [31:0]       m_tdata;             // [31:0] read_value
    logic [1:0]        m_tuser;             // [0] found, [1] evicted

    lru_key_value_cache #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Local copy of the cache contents and recency ranks (0 = most recent)
    logic [31:0]      slot_tag  [ENTRIES];
    logic [31:0]      slot_data [ENTRIES];
    logic             slot_live [ENTRIES];
    int unsigned      slot_age  [ENTRIES];
    logic [CAP_W-1:0] cap_setting;

    access_result_t   expected_results[$];

    int       errors          = 0;
    int       items_sent      = 0;
    int       results_checked = 0;
    int       caps_written    = 0;
    int       cycle_count     = 0;
    int       tx_gap_max      = 0;
    int       tx_burst_left   = 0;
    rx_mode_t rx_mode         = RX_STEADY;
    int       rx_tick         = 0;
    int       rx_hold         = 0;

    always #10 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    // Drive result-side backpressure according to the current mode
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_STEADY: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            RX_PERIODIC: begin
                m_tready <= (rx_tick % 7) >= 3;
            end
            default: begin
                if (rx_hold > 0) begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_hold  <= $urandom_range(1, 8);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Compute the outcome of one access and update the local cache copy
    function automatic access_result_t predict_access(input lkv_pkg::kind_t kind,
                                                      input logic [31:0] key,
                                                      input logic [31:0] val);
        access_result_t res;
        int             hit;
        int             fill;
        int             victim;
        int             limit;
        int unsigned    oldest;
        int unsigned    rank;
        res    = '0;
        hit    = -1;
        fill   = 0;
        victim = -1;
        oldest = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i]) begin
                fill++;
                if (hit < 0 && slot_tag[i] == key)
                    hit = i;
            end
        end
        if (hit >= 0) begin
            res.found = 1'b1;
            if (kind == lkv_pkg::KIND_LOOKUP)
                res.read_value = slot_data[hit];
            else
                slot_data[hit] = val;
            // Promote the hit entry; entries more recent than it age by one
            rank = slot_age[hit];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && i != hit && slot_age[i] < rank)
                    slot_age[i]++;
            slot_age[hit] = 0;
        end else if (kind == lkv_pkg::KIND_WRITE) begin
            // Zero acts as one, anything above the entry count as full size
            limit = (cap_setting == 0) ? 1 :
                    (int'(cap_setting) > ENTRIES) ? ENTRIES : int'(cap_setting);
            if (fill >= limit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_live[i] && (victim < 0 || slot_age[i] >= oldest)) begin
                        oldest = slot_age[i];
                        victim = i;
                    end
                end
                if (victim >= 0) begin
                    slot_live[victim] = 1'b0;
                    res.evicted       = 1'b1;
                end
            end
            if (victim < 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!slot_live[i] && victim < 0)
                        victim = i;
            end
            if (victim >= 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_live[i])
                        slot_age[i]++;
                slot_tag[victim]  = key;
                slot_data[victim] = val;
                slot_live[victim] = 1'b1;
                slot_age[victim]  = 0;
            end
        end
        return res;
    endfunction

    // Check each result transfer against the oldest prediction
    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b read_value=%08h evicted=%0b",
                         $realtime, m_tuser[0], m_tdata, m_tuser[1]);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.found) begin
                    errors++;
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $realtime, want.found, m_tuser[0]);
                end
                if (m_tdata !== want.read_value) begin
                    errors++;
                    $display("%0t: read_value mismatch, expected %08h actual %08h",
                             $realtime, want.read_value, m_tdata);
                end
                if (m_tuser[1] !== want.evicted) begin
                    errors++;
                    $display("%0t: evicted mismatch, expected %0b actual %0b",
                             $realtime, want.evicted, m_tuser[1]);
                end
            end
        end
    end

    // Present one item and hold it until the transfer completes
    task automatic send_item(input lkv_pkg::kind_t kind, input logic [31:0] key,
                             input logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {val, key};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // Queue the prediction behind the ones still waiting
        expected_results = {expected_results, predict_access(kind, key, val)};
        items_sent++;
    endtask

    // Insert a random gap at the end of each burst
    task automatic pace_sender();
        if (tx_gap_max > 0) begin
            if (tx_burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max))
                    @(posedge aclk);
                tx_burst_left = $urandom_range(1, 16);
            end
            tx_burst_left--;
        end
    endtask

    // Stop sending until every prediction has been matched, then let the
    // pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4)
            @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_setting  = cap;
        caps_written++;
    endtask

    // Extreme keys and values, hits, misses and overwrite of a present key
    task automatic test_lookup_write_extremes();
        rx_mode    <= RX_COIN;
        tx_gap_max  = 0;
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(lkv_pkg::KIND_WRITE,  32'h8000_0000, 32'h7FFF_FFFF);
        send_item(lkv_pkg::KIND_WRITE,  32'h7FFF_FFFF, 32'h8000_0000);
        send_item(lkv_pkg::KIND_WRITE,  32'h0000_0000, 32'hFFFF_FFFF);
        send_item(lkv_pkg::KIND_WRITE,  32'hFFFF_FFFF, 32'h0000_0000);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h1234_5678);
        send_item(lkv_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        send_item(lkv_pkg::KIND_WRITE,  32'h0000_0000, 32'h1234_5678);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    endtask

    // Capacity lowered below the fill, zero, oversized and one
    task automatic test_capacity_corners();
        write_capacity(5'd2);
        send_item(lkv_pkg::KIND_WRITE,  32'h0000_0005, 32'hA5A5_A5A5);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0005, 32'h0000_0000);
        send_item(lkv_pkg::KIND_WRITE,  32'h0000_0006, 32'h5A5A_5A5A);
        write_capacity(5'd0);
        send_item(lkv_pkg::KIND_WRITE,  32'h0000_0007, 32'hDEAD_BEEF);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0007, 32'h0000_0000);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0006, 32'h0000_0000);
        write_capacity(5'd31);
        send_item(lkv_pkg::KIND_WRITE,  32'h0000_0008, 32'h0BAD_F00D);
        write_capacity(5'd1);
        send_item(lkv_pkg::KIND_WRITE,  32'h0000_0009, 32'hFFFF_0000);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0009, 32'h0000_0000);
        send_item(lkv_pkg::KIND_LOOKUP, 32'h0000_0008, 32'h0000_0000);
    endtask

    // One phase of random traffic over a small key pool so that hits,
    // overwrites and evictions are all frequent
    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                                    input int gap_max, input rx_mode_t mode,
                                    input int pool_n);
        logic [31:0]    pool [32];
        logic [31:0]    key;
        logic [31:0]    val;
        lkv_pkg::kind_t kind;
        int             roll;
        write_capacity(cap);
        rx_mode      <= mode;
        tx_gap_max    = gap_max;
        tx_burst_left = 0;
        foreach (pool[i])
            pool[i] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        for (int n = 0; n < n_items; n++) begin
            // Pause midway until the block has nothing left in flight
            if (n == n_items / 2)
                wait_drained();
            key  = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                                : $urandom;
            kind = ($urandom_range(0, 99) < 45) ? lkv_pkg::KIND_WRITE
                                                : lkv_pkg::KIND_LOOKUP;
            roll = $urandom_range(0, 19);
            case (roll)
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'h0000_0000;
                3:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            pace_sender();
            send_item(kind, key, val);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(5'd16, 150, 0, RX_STEADY,   20);
        run_random_phase(5'd1,  150, 4, RX_COIN,      3);
        run_random_phase(5'd4,  150, 6, RX_PERIODIC,  7);
        run_random_phase(5'd0,  150, 3, RX_BURSTY,    2);
        run_random_phase(5'd31, 150, 2, RX_COIN,     24);
        run_random_phase(5'd17, 150, 0, RX_PERIODIC, 20);
        run_random_phase(5'd8,  150, 5, RX_STEADY,   12);
        run_random_phase(5'd2,  150, 1, RX_BURSTY,    4);
        run_random_phase(5'd15, 150, 3, RX_COIN,     18);
        run_random_phase(CAP_W'($urandom_range(0, 31)), 150, 4, RX_PERIODIC,
                         $urandom_range(2, 24));
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            slot_tag[i]  = '0;
            slot_data[i] = '0;
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end
        cap_setting = lkv_pkg::CAP_RESET;

        repeat (10)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_lookup_write_extremes();
        test_capacity_corners();
        test_random_traffic();

        // Drain and allow the pipeline to go quiet
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (10)
            @(posedge aclk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $realtime, expected_results.size());
        end

        $display("tb: %0d accesses sent, %0d results checked", items_sent, results_checked);
        $display("tb: capacity written %0d times, covering zero, one, full and oversized",
                 caps_written);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches", errors);
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/lkv_pkg.sv
src/lkv_cell.sv
src/lru_key_value_cache.sv
dv/tb.sv
